>>> rtl/core/mte_pkg.sv
// Shared types and constants for the multi-turn encoder tracker.
package mte_pkg;

  // Default angle field width of the encoder reply.
  localparam int ANGLE_BITS_DEF = 14;
  // Width of the wrapping turn counter.
  localparam int TURN_BITS = 18;
  // Reply word and position widths.
  localparam int WORD_BITS = 16;
  localparam int POS_BITS  = 32;
  localparam int CNT_BITS  = 32;
  // Bit position of the sensor error flag inside the reply word.
  localparam int ERR_BIT = 14;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_SENSOR_ERR = 2'd1,
    STATUS_PARITY_ERR = 2'd2
  } status_t;

  // Function codes of an input beat.
  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_ZERO   = 1'b1
  } func_t;

  // Outcome of checking one reply word.
  typedef struct packed {
    status_t status;
    logic    good;
    logic    clear;
  } chk_t;

endpackage

>>> rtl/core/multiturn_encoder_tracker_unit.sv
// Top level of the multi-turn encoder tracker.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  in      | input     | in_valid/in_ready  | func, reply_word
//  out     | output    | out_valid/out_ready| status, position_counts, error_total,
//          |           |                    | clear_needed
//
// One beat enters per cycle while in_ready is high; its result passes through the
// input register, then the state update feeding the result register.
// Throughput is one beat per cycle while the output is not stalled, set by the state update loop.
// Synchronous reset clears all tracking state and empties both stages.
// A stalled output holds its result; the input register then fills and in_ready drops.
module multiturn_encoder_tracker_unit
  import mte_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 func,
  input  logic [WORD_BITS-1:0] reply_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic [POS_BITS-1:0]  position_counts,
  output logic [CNT_BITS-1:0]  error_total,
  output logic                 clear_needed
);

  logic                 s1_valid;
  logic                 s1_func;
  logic [WORD_BITS-1:0] s1_word;
  logic                 adv;
  logic                 step;
  chk_t                 chk;
  logic [POS_BITS-1:0]  pos_next;
  logic [CNT_BITS-1:0]  cnt_next;

  // Pipeline flow control
  assign adv      = !out_valid || out_ready;
  assign step     = s1_valid && adv;
  assign in_ready = !s1_valid || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func <= func;
      s1_word <= reply_word;
    end
  end

  mte_check u_check (
    .reply_word (s1_word),
    .chk        (chk)
  );

  mte_track #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_track (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .func     (s1_func),
    .angle    (s1_word[ANGLE_BITS-1:0]),
    .chk      (chk),
    .pos_next (pos_next),
    .cnt_next (cnt_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      status          <= chk.status;
      position_counts <= pos_next;
      error_total     <= cnt_next;
      clear_needed    <= chk.clear;
    end
  end

`ifndef SYNTHESIS
  // No beat is taken while the input register is full and cannot move on
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> (!s1_valid || adv))
    else $error("input accepted into a blocked stage");

  // A processed beat always lands in the result register
  a_step_out: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("processed beat lost");

  // A good zero request reports position zero
  a_zero_pos: assert property (@(posedge clk) disable iff (rst)
    (step && chk.good && s1_func == FUNC_ZERO) |=> (position_counts == '0))
    else $error("zero request did not report zero position");

  // Clear request only accompanies a sensor error status
  a_clear_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clear_needed) |-> (status == STATUS_SENSOR_ERR))
    else $error("clear request without sensor error");

  // On a rejected beat the reported error total is the reject count advanced by one
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    (step && !chk.good) |=> (error_total == $past(cnt_next)))
    else $error("reject count mismatch");
`endif

endmodule

>>> rtl/core/mte_check.sv
// Reply word checker: sensor error flag first, then even parity.
module mte_check
  import mte_pkg::*;
(
  input  logic [WORD_BITS-1:0] reply_word,
  output chk_t                 chk
);

  logic parity_bad;

  // Even parity over all 16 bits
  assign parity_bad = ^reply_word;

  // Classify the word; error flag wins over parity
  always_comb begin
    chk = '0;
    if (reply_word[ERR_BIT]) begin
      chk.status = STATUS_SENSOR_ERR;
      chk.clear  = 1'b1;
    end else if (parity_bad) begin
      chk.status = STATUS_PARITY_ERR;
    end else begin
      chk.status = STATUS_OK;
      chk.good   = 1'b1;
    end
  end

endmodule

>>> rtl/core/mte_track.sv
// Turn unwrapping state, origin, reject counter and position arithmetic.
module mte_track
  import mte_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  func,
  input  logic [ANGLE_BITS-1:0] angle,
  input  chk_t                  chk,
  output logic [POS_BITS-1:0]   pos_next,
  output logic [CNT_BITS-1:0]   cnt_next
);

  localparam int DW = ANGLE_BITS + 2;
  localparam logic signed [DW-1:0] HALF_REV = DW'(2 ** (ANGLE_BITS - 1));

  logic [ANGLE_BITS-1:0] last_angle, last_angle_next;
  logic [ANGLE_BITS-1:0] origin_angle, origin_angle_next;
  logic [TURN_BITS-1:0]  turn_count, turn_count_next;
  logic                  have_previous, have_previous_next;
  logic [CNT_BITS-1:0]   rejected_count;
  logic signed [DW-1:0]  delta;
  logic [POS_BITS-1:0]   turns_ext;

  // Signed jump from the last good angle
  assign delta = $signed({2'b00, angle}) - $signed({2'b00, last_angle});

  // Next state for this beat
  always_comb begin
    last_angle_next    = last_angle;
    origin_angle_next  = origin_angle;
    turn_count_next    = turn_count;
    have_previous_next = have_previous;
    cnt_next           = rejected_count;
    if (!chk.good) begin
      cnt_next = rejected_count + CNT_BITS'(1);
    end else if (func == FUNC_ZERO) begin
      origin_angle_next  = angle;
      last_angle_next    = angle;
      turn_count_next    = '0;
      have_previous_next = 1'b1;
    end else begin
      if (have_previous) begin
        if (delta > HALF_REV) begin
          turn_count_next = turn_count - TURN_BITS'(1);
        end else if (delta < -HALF_REV) begin
          turn_count_next = turn_count + TURN_BITS'(1);
        end
      end
      last_angle_next    = angle;
      have_previous_next = 1'b1;
    end
  end

  // Position: turns scaled by a revolution, plus angle, minus origin
  assign turns_ext = {{(POS_BITS-TURN_BITS){turn_count_next[TURN_BITS-1]}}, turn_count_next};
  assign pos_next  = (turns_ext << ANGLE_BITS)
                   + POS_BITS'(last_angle_next)
                   - POS_BITS'(origin_angle_next);

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      last_angle     <= '0;
      origin_angle   <= '0;
      turn_count     <= '0;
      have_previous  <= 1'b0;
      rejected_count <= '0;
    end else if (step) begin
      last_angle     <= last_angle_next;
      origin_angle   <= origin_angle_next;
      turn_count     <= turn_count_next;
      have_previous  <= have_previous_next;
      rejected_count <= cnt_next;
    end
  end

endmodule

>>> sim/multiturn_encoder_tracker_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the multi-turn encoder tracker: random handshakes, scoreboard.
module multiturn_encoder_tracker_unit_tb;
  import mte_pkg::*;

  localparam int AB            = ANGLE_BITS_DEF;
  localparam int HALF_TURN     = 1 << (AB - 1);
  localparam int RANDOM_BEATS  = 800;
  localparam int IDLE_LIMIT    = 1000;
  localparam int LONG_HOLD     = 120;
  localparam int HOLD_AFTER    = 300;
  localparam int TAIL_CYCLES   = 8;

  typedef struct {
    func_t                fn;
    logic [WORD_BITS-1:0] word;
    int                   gap;
  } reply_item_t;

  typedef struct {
    status_t             status;
    logic [POS_BITS-1:0] position;
    logic [CNT_BITS-1:0] errors;
    logic                clear;
  } tracker_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 func = 1'b0;
  logic [WORD_BITS-1:0] reply_word = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           status;
  logic [POS_BITS-1:0]  position_counts;
  logic [CNT_BITS-1:0]  error_total;
  logic                 clear_needed;

  // beats seen at the last rising edge
  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;

  reply_item_t     reply_queue[$];
  tracker_result_t results_due[$];

  int fails       = 0;
  int results_got = 0;
  int idle_cycles = 0;
  int send_gap    = 0;
  int recv_wait   = 0;
  bit long_hold_done = 1'b0;

  // tracker state mirror
  logic [AB-1:0]        trk_last    = '0;
  logic [TURN_BITS-1:0] trk_turns   = '0;
  logic [AB-1:0]        trk_origin  = '0;
  logic                 trk_primed  = 1'b0;
  logic [CNT_BITS-1:0]  trk_rejects = '0;

  multiturn_encoder_tracker_unit dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .func            (func),
    .reply_word      (reply_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .position_counts (position_counts),
    .error_total     (error_total),
    .clear_needed    (clear_needed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Reply word with even parity over all 16 bits, error flag clear.
  function automatic logic [WORD_BITS-1:0] sealed(logic [AB-1:0] angle);
    return {^angle, 1'b0, angle};
  endfunction

  // Sender idles in random stretches, with a back-to-back run every third block.
  function automatic void queue_reply(func_t fn, logic [WORD_BITS-1:0] word);
    reply_item_t it;
    it.fn   = fn;
    it.word = word;
    it.gap  = (((reply_queue.size() / 120) % 3) == 1) ? 0 : $urandom_range(0, 11);
    reply_queue.push_back(it);
  endfunction

  // Updates the mirrored state for one accepted beat and returns its result.
  function automatic tracker_result_t track_word(func_t fn, logic [WORD_BITS-1:0] word);
    tracker_result_t     r;
    logic [AB-1:0]       angle;
    int                  delta;
    logic [POS_BITS-1:0] turns_wide;
    r.status = STATUS_OK;
    r.clear  = 1'b0;
    angle    = word[AB-1:0];
    if (word[ERR_BIT]) begin
      // sensor error wins over parity, counted once
      r.status    = STATUS_SENSOR_ERR;
      r.clear     = 1'b1;
      trk_rejects = trk_rejects + 1'b1;
    end else if (^word) begin
      r.status    = STATUS_PARITY_ERR;
      trk_rejects = trk_rejects + 1'b1;
    end else if (fn == FUNC_ZERO) begin
      trk_origin = angle;
      trk_last   = angle;
      trk_turns  = '0;
      trk_primed = 1'b1;
    end else begin
      // a jump past half a revolution is a wrap the other way
      if (trk_primed) begin
        delta = int'(angle) - int'(trk_last);
        if (delta > HALF_TURN) trk_turns = trk_turns - 1'b1;
        else if (delta < -HALF_TURN) trk_turns = trk_turns + 1'b1;
      end
      trk_last   = angle;
      trk_primed = 1'b1;
    end
    turns_wide = {{(POS_BITS-TURN_BITS){trk_turns[TURN_BITS-1]}}, trk_turns};
    r.position = (turns_wide << AB) + trk_last - trk_origin;
    r.errors   = trk_rejects;
    return r;
  endfunction

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // Sender: one item in flight, payload held until its beat.
  always @(negedge clk) begin : drive
    logic        nv;
    reply_item_t it;
    nv = in_valid;
    if (!rst) begin
      if (in_valid && in_taken) nv = 1'b0;
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (reply_queue.size() > 0) begin
          it = reply_queue.pop_front();
          func       <= it.fn;
          reply_word <= it.word;
          nv         = 1'b1;
          send_gap   = it.gap;
        end
      end
    end
    in_valid <= nv;
  end

  // Receiver: random wait before each beat, one long hold to back up the input.
  always @(negedge clk) begin : receive
    logic nr;
    nr = out_ready;
    if (!rst) begin
      if (out_ready && out_taken) begin
        nr = 1'b0;
        recv_wait = (((results_got / 100) % 3) == 2) ? 0 : $urandom_range(0, 11);
        if (!long_hold_done && results_got >= HOLD_AFTER) begin
          recv_wait      = LONG_HOLD;
          long_hold_done = 1'b1;
        end
      end
      if (!nr) begin
        if (recv_wait > 0) recv_wait--;
        else nr = 1'b1;
      end
    end
    out_ready <= nr;
  end

  // Predict on input beats, compare on output beats, watch for a hang.
  always @(posedge clk) begin : observe
    tracker_result_t want;
    if (rst) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= in_valid && in_ready;
      out_taken <= out_valid && out_ready;
      if (in_valid && in_ready) results_due.push_back(track_word(func_t'(func), reply_word));
      if (out_valid && out_ready) begin
        results_got++;
        if (results_due.size() == 0) begin
          fails++;
          $display("%0t: unexpected result beat, status %0d position %0h errors %0h clear %0b",
                   $time, status, position_counts, error_total, clear_needed);
        end else begin
          want = results_due.pop_front();
          check_field("status", 32'(want.status), 32'(status));
          check_field("position_counts", want.position, position_counts);
          check_field("error_total", want.errors, error_total);
          check_field("clear_needed", 32'(want.clear), 32'(clear_needed));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    int angle;
    int step;
    int jitter;
    int run;
    int pick;
    int n;

    // Directed: first sample, wraps both ways, exact half turn, origin, rejects.
    queue_reply(FUNC_SAMPLE, sealed(14'h3FFF));
    queue_reply(FUNC_SAMPLE, sealed(14'h0000));
    queue_reply(FUNC_SAMPLE, sealed(14'h2000));
    queue_reply(FUNC_SAMPLE, sealed(14'h0000));
    queue_reply(FUNC_SAMPLE, sealed(14'h2001));
    queue_reply(FUNC_SAMPLE, sealed(14'h0000));
    queue_reply(FUNC_SAMPLE, sealed(14'h3FFF));
    queue_reply(FUNC_SAMPLE, sealed(14'h3FFF));
    queue_reply(FUNC_ZERO, sealed(14'd5000));
    queue_reply(FUNC_SAMPLE, 16'hC000);
    queue_reply(FUNC_SAMPLE, 16'h4000);
    queue_reply(FUNC_SAMPLE, 16'h0001);
    queue_reply(FUNC_ZERO, sealed(14'd1234) ^ 16'h8000);
    queue_reply(FUNC_ZERO, 16'h7FFF);
    queue_reply(FUNC_SAMPLE, 16'hFFFF);
    queue_reply(FUNC_SAMPLE, sealed(14'h0000));
    queue_reply(FUNC_ZERO, sealed(14'h3FFF));
    queue_reply(FUNC_SAMPLE, sealed(14'h0000));
    queue_reply(FUNC_SAMPLE, sealed(14'h1555));
    queue_reply(FUNC_SAMPLE, sealed(14'h2AAA));

    // Random: runs of steady rotation with rejects, re-zeroing and noise mixed in.
    angle = 0;
    n = 0;
    while (n < RANDOM_BEATS) begin
      step   = int'($urandom_range(0, 24000)) - 12000;
      jitter = 64;
      if ($urandom_range(0, 9) == 0) begin
        step   = HALF_TURN;
        jitter = 0;
      end
      run = $urandom_range(4, 40);
      for (int k = 0; k < run && n < RANDOM_BEATS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          angle = (angle + step + int'($urandom_range(0, jitter)) - jitter / 2) & 32'h3FFF;
          queue_reply(FUNC_SAMPLE, sealed(angle[AB-1:0]));
        end else if (pick < 84) begin
          angle = $urandom_range(0, 16383);
          queue_reply(FUNC_ZERO, sealed(angle[AB-1:0]));
        end else if (pick < 89) begin
          queue_reply(func_t'(1'($urandom_range(0, 1))),
                      {1'($urandom_range(0, 1)), 1'b1, 14'($urandom_range(0, 16383))});
        end else if (pick < 94) begin
          queue_reply(func_t'(1'($urandom_range(0, 1))),
                      sealed(14'($urandom_range(0, 16383))) ^ 16'h8000);
        end else begin
          queue_reply(func_t'(1'($urandom_range(0, 1))), 16'($urandom_range(0, 65535)));
        end
        n++;
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // drain: all items sent, then all results back, then a short tail
    while (reply_queue.size() != 0 || in_valid) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/mte_pkg.sv
rtl/core/mte_check.sv
rtl/core/mte_track.sv
rtl/core/multiturn_encoder_tracker_unit.sv
sim/multiturn_encoder_tracker_unit_tb.sv
